// File: rtl/encoder_angle_velocity_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder angle and velocity tracker
// Shared helpers that wrap a clocked concurrent assertion with reset disable.
// ----------------------------------------------------------------------------
`ifndef ENCODER_ANGLE_VELOCITY_TRACKER_MACROS_SVH
`define ENCODER_ANGLE_VELOCITY_TRACKER_MACROS_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define EVT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// Non-overlapping implication: the consequent holds in the next cycle.
`define EVT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// File: rtl/evt_pkg.sv
// ----------------------------------------------------------------------------
// evt_pkg
// Widths, constants and shared types of the encoder angle and velocity tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package evt_pkg;

  // Field widths of the sample and result words.
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int MECH_W  = 12;
  localparam int TURN_W  = 16;
  localparam int TOTAL_W = 29;
  localparam int VEL_W   = 26;

  // Configuration registers.
  localparam int RC_W       = 20;
  localparam int DB_W       = 16;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [RC_W-1:0] RC_RESET = 20'd15915;
  localparam logic [DB_W-1:0] DB_RESET = 16'd13;

  typedef enum logic {
    REG_FILTER_RC = 1'b0,
    REG_DEADBAND  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [RC_W-1:0] filter_rc;
    logic [DB_W-1:0] deadband;
  } cfg_t;

  // Time step clamp and divisor width.
  localparam int DT_W  = 17;
  localparam int DIV_W = 21;
  localparam logic [TIME_W-1:0] DT_MIN = 32'd100;
  localparam logic [TIME_W-1:0] DT_MAX = 32'd100000;

  // One count per microsecond is 1e6 counts/s; Q8 scaling gives 256e6.
  localparam logic signed [29:0] VEL_SCALE = 30'sd256000000;

  localparam logic signed [TURN_W-1:0] TURN_LIMIT = 16'sd32767;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// File: rtl/evt_sample_if.sv
// ----------------------------------------------------------------------------
// evt_sample_if
// Valid/ready channel that carries one encoder sample word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface evt_sample_if import evt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] angle_high_byte;
  logic [BYTE_W-1:0] angle_low_byte;
  logic [TIME_W-1:0] sample_time_us;

  modport source (output valid, angle_high_byte, angle_low_byte, sample_time_us,
                  input ready);
  modport sink   (input valid, angle_high_byte, angle_low_byte, sample_time_us,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/evt_result_if.sv
// ----------------------------------------------------------------------------
// evt_result_if
// Valid/ready channel that carries one angle and velocity result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface evt_result_if import evt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MECH_W-1:0]         mech_angle;
  logic signed [TURN_W-1:0]  turn_count;
  logic signed [TOTAL_W-1:0] total_angle;
  logic signed [VEL_W-1:0]   velocity_cps;

  modport source (output valid, mech_angle, turn_count, total_angle, velocity_cps,
                  input ready);
  modport sink   (input valid, mech_angle, turn_count, total_angle, velocity_cps,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/evt_cfg_regs.sv
// ----------------------------------------------------------------------------
// evt_cfg_regs
// APB register bank holding the filter time constant and the deadband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module evt_cfg_regs import evt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  reg_idx_t idx;
  logic     wr_en;

  // Registers sit on word boundaries; the byte offset bits are ignored.
  assign idx    = reg_idx_t'(paddr[PADDR_W-1]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_rc <= RC_RESET;
      cfg.deadband  <= DB_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_FILTER_RC: cfg.filter_rc <= pwdata[RC_W-1:0];
        REG_DEADBAND:  cfg.deadband  <= pwdata[DB_W-1:0];
        default:       cfg           <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILTER_RC: prdata = APB_DATA_W'(cfg.filter_rc);
      REG_DEADBAND:  prdata = APB_DATA_W'(cfg.deadband);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/evt_ser_mul.sv
// ----------------------------------------------------------------------------
// evt_ser_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module evt_ser_mul import evt_pkg::*; #(
  parameter int A_W = 33,
  parameter int B_W = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output unit_stat_t              stat,
  output logic      [A_W+B_W:0]   product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W:0]     hi;
  logic [B_W-1:0]   lo;
  logic [A_W-1:0]   a_reg;
  logic [CNT_W-1:0] cnt;
  logic [A_W:0]     sum;

  // The multiplier shifts out of the low end while product bits shift in.
  assign sum     = hi + (lo[0] ? {1'b0, a_reg} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(B_W);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      a_reg <= a;
    end else if (stat.busy) begin
      hi <= {1'b0, sum[A_W:1]};
      lo <= {sum[0], lo[B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/evt_ser_div.sv
// ----------------------------------------------------------------------------
// evt_ser_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module evt_ser_div import evt_pkg::*; #(
  parameter int Q_W = 33,
  parameter int D_W = 21
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [Q_W+D_W-1:0] dividend,
  input  wire logic [D_W-1:0]     divisor,
  output unit_stat_t              stat,
  output logic      [Q_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dvs;
  logic [Q_W-1:0]   sr;
  logic [CNT_W-1:0] cnt;
  logic [D_W+1:0]   diff;
  logic             ge;

  // The caller guarantees the quotient fits Q_W bits, so the top D_W
  // dividend bits already form a partial remainder below the divisor.
  assign diff     = {1'b0, rem, sr[Q_W-1]} - {2'b00, dvs};
  assign ge       = !diff[D_W+1];
  assign quotient = sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(Q_W);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[Q_W+D_W-1:Q_W];
      sr  <= dividend[Q_W-1:0];
      dvs <= divisor;
    end else if (stat.busy) begin
      rem <= ge ? diff[D_W-1:0] : {rem[D_W-2:0], sr[Q_W-1]};
      sr  <= {sr[Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/encoder_angle_velocity_tracker.sv
// ----------------------------------------------------------------------------
// encoder_angle_velocity_tracker
// Multi-turn angle and filtered velocity from magnetic encoder samples.
//
// Each word on the samples channel carries the two angle register bytes and
// a microsecond timestamp; each produces exactly one word on the results
// channel with the single-turn angle, the turn count, the total angle and the
// low-pass filtered velocity. The user is to write filter time constant and
// deadband over the APB port while the block is idle; the block does not enforce it.
// The time from acceptance to the next ready is set by the steps S_MUL, S_SUM,
// S_LOAD, S_DIV, S_FIN and S_OUT, mainly the serial multiplier (one bit of the time
// constant per cycle) and the serial divider (one quotient bit per cycle).
// The result word is registered in S_OUT after the divider; the very first sample
// after reset only primes the state and goes from S_IDLE straight to S_OUT.
// The result sits in an output register, so a new sample is taken while it
// waits; with a stalled receiver that sample is computed and then held, and
// the sample input stays not ready until the waiting word is taken.
// Reset is synchronous: turn count, filter state and priming are cleared and
// the registers return to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "encoder_angle_velocity_tracker_macros.svh"

module encoder_angle_velocity_tracker import evt_pkg::*; #(
  parameter int ANGLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  evt_sample_if.sink                 samples,
  evt_result_if.source               results
);

  localparam int A     = ANGLE_BITS;
  localparam int Y_W   = A + 22;        // filter state, Q8
  localparam int Y_M   = Y_W - 1;       // magnitude bits of the filter state
  localparam int N_W   = Y_M + RC_W + 1; // numerator magnitude bits
  localparam int NUM_W = N_W + 1;
  localparam int DK_W  = A + 30;
  localparam logic [A+3:0] TURN_THR = {2'b01, {(A + 2){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_LOAD = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;

  logic                     primed;
  logic [A-1:0]             prev_angle;
  logic signed [TURN_W-1:0] turn;
  logic [TIME_W-1:0]        prev_time;
  logic signed [Y_W-1:0]    y;
  logic signed [A-1:0]      d_reg;
  logic [DT_W-1:0]          dt_reg;
  logic signed [DK_W-1:0]   dk;
  logic signed [NUM_W-1:0]  num;
  logic                     nsign;

  logic                     accept;
  logic [15:0]              raw16;
  logic [A-1:0]             angle;
  logic signed [A:0]        jump;
  logic [A:0]               jump_mag;
  logic [A+3:0]             mag5;
  logic                     big_jump;
  logic [TIME_W-1:0]        dt_raw;
  logic [DT_W-1:0]          dt_clamp;
  logic [Y_W-1:0]           y_mag;

  unit_stat_t               mul_stat, div_stat;
  logic                     mul_start, div_start;
  logic [N_W-1:0]           prod;
  logic signed [NUM_W-1:0]  prod_ext;
  logic signed [NUM_W-1:0]  num_abs;
  logic [DIV_W-1:0]         divisor;
  logic [Y_M-1:0]           quot;
  logic signed [Y_W-1:0]    y_new;
  logic signed [Y_W-1:0]    y_adj;
  logic signed [TURN_W+A-1:0] total_full;

  evt_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---- sample decode ------------------------------------------------------
  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;

  assign raw16    = {samples.angle_high_byte, samples.angle_low_byte};
  assign angle    = raw16[A-1:0];
  assign jump     = $signed({1'b0, angle}) - $signed({1'b0, prev_angle});
  assign jump_mag = jump[A] ? (A + 1)'(-jump) : (A + 1)'(jump);
  // A jump of more than four fifths of a turn is taken as a wrap.
  assign mag5     = {3'b000, jump_mag} + {1'b0, jump_mag, 2'b00};
  assign big_jump = mag5 > TURN_THR;

  assign dt_raw   = samples.sample_time_us - prev_time;
  assign dt_clamp = (dt_raw < DT_MIN) ? DT_W'(DT_MIN) :
                    (dt_raw > DT_MAX) ? DT_W'(DT_MAX) : dt_raw[DT_W-1:0];

  assign y_mag = y[Y_W-1] ? Y_W'(-y) : Y_W'(y);

  // ---- serial arithmetic --------------------------------------------------
  assign mul_start = accept && primed;
  assign div_start = (state == S_LOAD);
  assign prod_ext  = $signed({1'b0, prod});
  assign num_abs   = num[NUM_W-1] ? -num : num;
  assign divisor   = DIV_W'(dt_reg) + DIV_W'(cfg.filter_rc);

  evt_ser_mul #(
    .A_W (Y_M),
    .B_W (RC_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (y_mag[Y_M-1:0]),
    .b       (cfg.filter_rc),
    .stat    (mul_stat),
    .product (prod)
  );

  evt_ser_div #(
    .Q_W (Y_M),
    .D_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_abs[N_W-1:0]),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quot)
  );

  // Quotient is the magnitude, so truncation is toward zero after the sign.
  always_comb begin
    if (quot < Y_M'({cfg.deadband, 8'h00})) begin
      y_new = '0;
    end else if (nsign) begin
      y_new = -$signed({1'b0, quot});
    end else begin
      y_new = $signed({1'b0, quot});
    end
  end

  // ---- sequencer ----------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = primed ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          state_next = S_SUM;
        end
      end
      S_SUM:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIV;
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = S_OUT;
      S_OUT: begin
        if (!results.valid || results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      primed     <= 1'b0;
      prev_angle <= '0;
      prev_time  <= '0;
      turn       <= '0;
      y          <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        primed     <= 1'b1;
        prev_angle <= angle;
        prev_time  <= samples.sample_time_us;
        if (primed && big_jump) begin
          if (!jump[A] && jump != '0) begin
            if (turn > -TURN_LIMIT) begin
              turn <= turn - TURN_W'(1);
            end
          end else if (turn < TURN_LIMIT) begin
            turn <= turn + TURN_W'(1);
          end
        end
      end
      if (state == S_FIN) begin
        y <= y_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_reg  <= $signed(jump[A-1:0]);
      dt_reg <= dt_clamp;
    end
    if (state == S_MUL) begin
      dk <= DK_W'(d_reg) * DK_W'(VEL_SCALE);
    end
    if (state == S_SUM) begin
      num <= (y[Y_W-1] ? -prod_ext : prod_ext) + NUM_W'(dk);
    end
    if (state == S_LOAD) begin
      nsign <= num[NUM_W-1];
    end
  end

  // ---- output register ----------------------------------------------------
  assign total_full = {turn, prev_angle};
  assign y_adj      = y + $signed({{(Y_W - 8){1'b0}}, {8{y[Y_W-1]}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_OUT && (!results.valid || results.ready)) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!results.valid || results.ready)) begin
      results.mech_angle   <= MECH_W'(prev_angle);
      results.turn_count   <= turn;
      results.total_angle  <= TOTAL_W'(total_full);
      results.velocity_cps <= VEL_W'($signed(y_adj[Y_W-1:8]));
    end
  end

  // ---- assertions ---------------------------------------------------------
  `EVT_ASSERT_IMP(a_mul_done_in_mul, clk, rst, mul_stat.done, state == S_MUL)
  `EVT_ASSERT_IMP(a_div_done_in_div, clk, rst, div_stat.done, state == S_DIV)
  `EVT_ASSERT_IMP(a_turn_saturates, clk, rst, 1'b1, turn != 16'sh8000)
  `EVT_ASSERT_IMP(a_deadband_applied, clk, rst, state == S_OUT && $past(state) == S_FIN, y == '0 || y_mag >= Y_W'({$past(cfg.deadband), 8'h00}))
  `EVT_ASSERT_IMP(a_valid_from_out, clk, rst, $rose(results.valid), $past(state) == S_OUT)

endmodule

`default_nettype wire
